### hdl/irc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package irc_pkg;

  localparam int SEGMENT_DEPTH = 64;
  localparam int SEG_AW = (SEGMENT_DEPTH > 1) ? $clog2(SEGMENT_DEPTH) : 1;
  localparam int SEG_W = 18;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd13;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

endpackage

`default_nettype wire

### hdl/irc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module irc_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/ir_carrier_burst_transmitter.sv
// ir carrier burst transmitter
// the accepted item is held in the run state, and the result strobe is registered from that state
// busy stays high in the run state, so no new item is accepted until the state is idle again
// results go out for one cycle each; the receiver cannot stall
// reset (rst_n low, synchronous) stops sending, clears counters, half period = 13;
// the segment memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

module ir_carrier_burst_transmitter
  import irc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [5:0]  in_segment_index,
  input  wire logic        in_segment_level,
  input  wire logic [15:0] in_segment_cycles,
  input  wire logic        in_segment_is_last,
  input  wire logic [15:0] in_repeat_count,
  output logic             out_strobe,
  output logic             out_emitter_pin,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic             out_rejected,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_half_period_ticks
);

  state_t state_r, state_nxt;

  logic [1:0]  func_r;
  logic [5:0]  idx_r;
  logic        lvl_r;
  logic [15:0] cyc_r;
  logic        last_r;
  logic [15:0] reps_r;

  logic [15:0]       hp_r;
  logic [SEG_AW-1:0] pos_r, pos_nxt;
  logic [15:0]       cd_r, cd_nxt;
  logic [15:0]       tih_r, tih_nxt;
  logic              low_r, low_nxt;
  logic [15:0]       rl_r, rl_nxt;
  logic              send_r, send_nxt;

  logic strobe_r, strobe_nxt;
  logic pin_r, pin_nxt;
  logic bres_r, bres_nxt;
  logic done_r, done_nxt;
  logic rej_r, rej_nxt;

  logic              accept;
  logic              wr_en;
  logic [SEG_W-1:0]  rd_data;
  logic [31:0]       idx_ext;
  logic              idx_ok;
  logic [31:0]       pos_inc;
  logic [15:0]       hp_eff;
  logic [16:0]       tih_sum;
  logic [15:0]       cd_inc;
  logic [15:0]       rl_dec;
  logic              e_lvl;
  logic [15:0]       e_cyc;
  logic              e_last;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign idx_ext = 32'(idx_r);
  assign idx_ok  = idx_ext < 32'(SEGMENT_DEPTH);
  assign pos_inc = 32'(pos_r) + 32'd1;
  assign hp_eff  = (hp_r == 16'd0) ? 16'd1 : hp_r;
  assign tih_sum = {1'b0, tih_r} + 17'd1;
  assign cd_inc  = cd_r + 16'd1;
  assign rl_dec  = rl_r - 16'd1;
  assign e_lvl   = rd_data[0];
  assign e_cyc   = rd_data[16:1];
  assign e_last  = rd_data[17];

  assign wr_en = (state_r == ST_RUN) && (func_r == FUNC_WRITE) && !send_r
                 && (cyc_r != 16'd0) && idx_ok;

  irc_ram #(
    .WIDTH (SEG_W),
    .DEPTH (SEGMENT_DEPTH)
  ) u_seg_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_ext[SEG_AW-1:0]),
    .wr_data ({last_r, cyc_r, lvl_r}),
    .rd_en   (accept),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    cd_nxt     = cd_r;
    tih_nxt    = tih_r;
    low_nxt    = low_r;
    rl_nxt     = rl_r;
    send_nxt   = send_r;
    strobe_nxt = 1'b0;
    pin_nxt    = pin_r;
    bres_nxt   = bres_r;
    done_nxt   = done_r;
    rej_nxt    = rej_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        state_nxt  = ST_IDLE;
        strobe_nxt = 1'b1;
        pin_nxt    = 1'b0;
        done_nxt   = 1'b0;
        rej_nxt    = 1'b0;
        if (func_r == FUNC_WRITE) begin
          rej_nxt = send_r || (cyc_r == 16'd0) || !idx_ok;
        end else if (func_r == FUNC_START) begin
          if (send_r) begin
            rej_nxt = 1'b1;
          end else begin
            pos_nxt  = '0;
            cd_nxt   = '0;
            tih_nxt  = '0;
            low_nxt  = 1'b0;
            rl_nxt   = reps_r;
            send_nxt = (reps_r != 16'd0);
          end
        end else if (func_r == FUNC_TICK && send_r) begin
          pin_nxt = e_lvl && !low_r;
          tih_nxt = tih_sum[15:0];
          if (tih_sum >= {1'b0, hp_eff}) begin
            tih_nxt = '0;
            if (!low_r) begin
              low_nxt = 1'b1;
            end else begin
              low_nxt = 1'b0;
              cd_nxt  = cd_inc;
              if (cd_inc >= e_cyc) begin
                cd_nxt = '0;
                if (e_last) begin
                  pos_nxt = '0;
                  rl_nxt  = rl_dec;
                  if (rl_dec == 16'd0) begin
                    send_nxt = 1'b0;
                    done_nxt = 1'b1;
                  end
                end else if (pos_inc == 32'(SEGMENT_DEPTH)) begin
                  pos_nxt = '0;
                end else begin
                  pos_nxt = pos_inc[SEG_AW-1:0];
                end
              end
            end
          end
        end
        bres_nxt = send_nxt;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      hp_r     <= HALF_PERIOD_RESET;
      pos_r    <= '0;
      cd_r     <= '0;
      tih_r    <= '0;
      low_r    <= 1'b0;
      rl_r     <= '0;
      send_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      cd_r     <= cd_nxt;
      tih_r    <= tih_nxt;
      low_r    <= low_nxt;
      rl_r     <= rl_nxt;
      send_r   <= send_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        hp_r <= cfg_half_period_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      idx_r  <= in_segment_index;
      lvl_r  <= in_segment_level;
      cyc_r  <= in_segment_cycles;
      last_r <= in_segment_is_last;
      reps_r <= in_repeat_count;
    end
    pin_r  <= pin_nxt;
    bres_r <= bres_nxt;
    done_r <= done_nxt;
    rej_r  <= rej_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_emitter_pin = pin_r;
  assign out_busy_res    = bres_r;
  assign out_done_res    = done_r;
  assign out_rejected    = rej_r;

`ifndef NO_ASSERTIONS
  a_run_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |=> out_strobe)
    else $error("processing cycle without result strobe");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  a_done_ends_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_done_res |-> !out_busy_res && !send_r)
    else $error("done reported while still sending");

  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == ST_RUN && func_r == FUNC_WRITE && !send_r)
    else $error("segment memory written outside a segment write");
`endif

endmodule

`default_nettype wire
